>>> src/ssmf_pkg.sv
// Shared types and constants of the scan sliding mean filter.
`timescale 1ns / 1ps

package ssmf_pkg;

    // Width and reset value of the half window register.
    localparam int CFG_BITS = 4;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_CENTRE,
        ST_MUL1,
        ST_MUL2,
        ST_EMIT_RAW,
        ST_EMIT_MEAN,
        ST_FL_READ,
        ST_FL_EMIT
    } ssmf_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic update;
        logic centre_rd;
        logic mul;
        logic fin;
        logic load_out;
        logic out_mean;
        logic out_flush;
        logic flush_init;
        logic flush_rd;
        logic flush_dec;
        logic clear;
    } ssmf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_centre;
        logic do_mean;
        logic last;
        logic fc_zero;
        logic out_free;
    } ssmf_status_t;

endpackage

>>> src/ssmf_if.sv
// Handshake interfaces of the sample input and the filtered output channels.
`timescale 1ns / 1ps

interface ssmf_in_if #(
    parameter int RANGE_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [RANGE_BITS-1:0] range_mm;
    logic                  range_valid;
    logic                  last_in_scan;

    modport source (output valid, range_mm, range_valid, last_in_scan, input ready);
    modport sink   (input valid, range_mm, range_valid, last_in_scan, output ready);
endinterface

interface ssmf_out_if #(
    parameter int RANGE_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [RANGE_BITS-1:0] filtered_mm;
    logic                  filtered_valid;
    logic                  last_of_scan;

    modport source (output valid, filtered_mm, filtered_valid, last_of_scan, input ready);
    modport sink   (input valid, filtered_mm, filtered_valid, last_of_scan, output ready);
endinterface

>>> src/scan_sliding_mean_filter.sv
// Top level of the scan sliding mean filter.
//
//  Channel    Direction  Transfer moves
//  samples    in         range_mm, range_valid, last_in_scan
//  filtered   out        filtered_mm, filtered_valid, last_of_scan
//  cfg_wr_*   in         half_window, written when cfg_wr_en is high
//
// A sample takes the accept, update and centre states; a raw centre is then emitted,
// and a mean first takes the reciprocal multiply and correction states. The last
// sample of a scan adds a flush read and emit per sample and a read to close it.
// One window memory port serves the drop, centre and flush reads in turn.
// A stalled output holds the block only when a further result must be loaded.
// Reset clears the scan state and sets the half window to 5.
`timescale 1ns / 1ps

module scan_sliding_mean_filter #(
    parameter int MAX_HALF_WINDOW = 15,
    parameter int RANGE_BITS      = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ssmf_pkg::CFG_BITS-1:0] cfg_wr_data,
    ssmf_in_if.sink                       samples,
    ssmf_out_if.source                    filtered
);

    ssmf_pkg::ssmf_cmd_t    cmd;
    ssmf_pkg::ssmf_status_t status;

    ssmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ssmf_datapath #(
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .RANGE_BITS      (RANGE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_mm          (samples.range_mm),
        .in_valid_flag  (samples.range_valid),
        .in_last        (samples.last_in_scan),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (filtered.valid),
        .out_ready      (filtered.ready),
        .out_mm         (filtered.filtered_mm),
        .out_valid_flag (filtered.filtered_valid),
        .out_last       (filtered.last_of_scan)
    );

endmodule

>>> src/ssmf_ctrl.sv
// Controller state machine of the scan sliding mean filter.
`timescale 1ns / 1ps

module ssmf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ssmf_pkg::ssmf_status_t status,
    output ssmf_pkg::ssmf_cmd_t    cmd
);

    ssmf_pkg::ssmf_state_t state_reg;
    ssmf_pkg::ssmf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssmf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssmf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ssmf_pkg::ST_UPDATE;
                end
            end
            ssmf_pkg::ST_UPDATE:
            begin
                state_next = ssmf_pkg::ST_CENTRE;
            end
            ssmf_pkg::ST_CENTRE:
            begin
                priority if (!status.has_centre)
                begin
                    state_next = status.last ? ssmf_pkg::ST_FL_READ : ssmf_pkg::ST_IDLE;
                end
                else if (status.do_mean)
                begin
                    state_next = ssmf_pkg::ST_MUL1;
                end
                else
                begin
                    state_next = ssmf_pkg::ST_EMIT_RAW;
                end
            end
            ssmf_pkg::ST_MUL1:
            begin
                state_next = ssmf_pkg::ST_MUL2;
            end
            ssmf_pkg::ST_MUL2:
            begin
                state_next = ssmf_pkg::ST_EMIT_MEAN;
            end
            ssmf_pkg::ST_EMIT_RAW, ssmf_pkg::ST_EMIT_MEAN:
            begin
                if (status.out_free)
                begin
                    state_next = status.last ? ssmf_pkg::ST_FL_READ : ssmf_pkg::ST_IDLE;
                end
            end
            ssmf_pkg::ST_FL_READ:
            begin
                state_next = status.fc_zero ? ssmf_pkg::ST_IDLE : ssmf_pkg::ST_FL_EMIT;
            end
            ssmf_pkg::ST_FL_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ssmf_pkg::ST_FL_READ;
                end
            end
            default:
            begin
                state_next = ssmf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ssmf_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ssmf_pkg::ST_UPDATE:
            begin
                cmd.update    = 1'b1;
                cmd.centre_rd = 1'b1;
            end
            ssmf_pkg::ST_CENTRE:
            begin
                cmd.flush_init = !status.has_centre && status.last;
            end
            ssmf_pkg::ST_MUL1:
            begin
                cmd.mul = 1'b1;
            end
            ssmf_pkg::ST_MUL2:
            begin
                cmd.fin = 1'b1;
            end
            ssmf_pkg::ST_EMIT_RAW, ssmf_pkg::ST_EMIT_MEAN:
            begin
                cmd.load_out   = status.out_free;
                cmd.out_mean   = (state_reg == ssmf_pkg::ST_EMIT_MEAN);
                cmd.flush_init = status.out_free && status.last;
            end
            ssmf_pkg::ST_FL_READ:
            begin
                cmd.clear    = status.fc_zero;
                cmd.flush_rd = !status.fc_zero;
            end
            ssmf_pkg::ST_FL_EMIT:
            begin
                cmd.load_out  = status.out_free;
                cmd.out_flush = 1'b1;
                cmd.flush_dec = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> src/ssmf_datapath.sv
// Datapath of the scan sliding mean filter: window memory, running sums,
// reciprocal divider and output register.
`timescale 1ns / 1ps

module ssmf_datapath #(
    parameter int MAX_HALF_WINDOW = 15,
    parameter int RANGE_BITS      = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ssmf_pkg::CFG_BITS-1:0]   cfg_wr_data,
    input  logic [RANGE_BITS-1:0]           in_mm,
    input  logic                            in_valid_flag,
    input  logic                            in_last,
    input  ssmf_pkg::ssmf_cmd_t             cmd,
    output ssmf_pkg::ssmf_status_t          status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [RANGE_BITS-1:0]           out_mm,
    output logic                            out_valid_flag,
    output logic                            out_last
);

    localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int HW    = $clog2(MAX_HALF_WINDOW + 1);
    localparam int SW    = RANGE_BITS + CW;
    localparam int NW    = SW + 1;
    localparam int DW    = CW + 1;

    // Reciprocals of twice the valid count, scaled by 2**NW.
    logic [NW-1:0] recip_tab [0:DEPTH];

    for (genvar g = 0; g <= DEPTH; g++)
    begin : g_recip
        localparam logic [63:0] RV = (g == 0) ? 64'd0 : ((64'd1 << NW) / (64'd2 * g));
        assign recip_tab[g] = NW'(RV);
    end

    logic [ssmf_pkg::CFG_BITS-1:0] cfg_reg;
    logic [PW-1:0]                 head_reg;
    logic [SW-1:0]                 sum_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 seen_reg;
    logic [HW-1:0]                 fc_reg;
    logic                          out_valid_reg;

    logic [RANGE_BITS-1:0]         in_mm_reg;
    logic                          in_valid_reg;
    logic                          in_last_reg;
    logic [RANGE_BITS:0]           rd_reg;
    logic [2*NW-1:0]               prod_reg;
    logic [RANGE_BITS-1:0]         mean_reg;
    logic [RANGE_BITS-1:0]         out_mm_reg;
    logic                          out_flag_reg;
    logic                          out_last_reg;

    logic [RANGE_BITS:0]           mem [0:DEPTH-1];

    logic [HW-1:0]                 h;
    logic [CW-1:0]                 w;
    logic [PW-1:0]                 wr_addr;
    logic [PW-1:0]                 rd_addr;
    logic                          rd_en;
    logic [RANGE_BITS-1:0]         rd_mm;
    logic                          rd_flag;
    logic                          drop;
    logic [SW-1:0]                 sum_next;
    logic [CW-1:0]                 count_next;
    logic [CW-1:0]                 seen_next;
    logic [NW-1:0]                 numer;
    logic [DW-1:0]                 denom;
    logic [NW-1:0]                 q0;
    logic [NW+DW-1:0]              qd;
    logic [NW+DW-1:0]              rem;
    logic [NW-1:0]                 quot;
    logic                          out_free;

    // Address of the entry a given number of positions older than base.
    function automatic logic [PW-1:0] age_addr(input logic [PW-1:0] base,
                                               input logic [PW-1:0] off);
        logic [PW:0] diff;
        diff = {1'b0, base} - {1'b0, off};
        if (diff[PW])
        begin
            diff = diff + (PW+1)'(DEPTH);
        end
        return diff[PW-1:0];
    endfunction

    always_comb
    begin
        if (32'(cfg_reg) > MAX_HALF_WINDOW)
        begin
            h = HW'(MAX_HALF_WINDOW);
        end
        else
        begin
            h = HW'(cfg_reg);
        end
    end

    assign w       = CW'({h, 1'b1});
    assign wr_addr = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
    assign rd_mm   = rd_reg[RANGE_BITS-1:0];
    assign rd_flag = rd_reg[RANGE_BITS];
    assign rd_en   = cmd.accept | cmd.centre_rd | cmd.flush_rd;

    always_comb
    begin
        priority if (cmd.accept)
        begin
            // The sample leaving a full window; read before it is overwritten.
            rd_addr = age_addr(head_reg, PW'({h, 1'b0}));
        end
        else if (cmd.centre_rd)
        begin
            rd_addr = age_addr(head_reg, PW'(h));
        end
        else
        begin
            rd_addr = age_addr(head_reg, PW'(fc_reg - HW'(1)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mem[wr_addr] <= {in_valid_flag, in_mm};
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign drop = (seen_reg >= w) && rd_flag;

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (drop)
        begin
            sum_next   = sum_next - SW'(rd_mm);
            count_next = count_next - CW'(1);
        end
        if (in_valid_reg)
        begin
            sum_next   = sum_next + SW'(in_mm_reg);
            count_next = count_next + CW'(1);
        end
        seen_next = (seen_reg < w) ? seen_reg + CW'(1) : w;
    end

    // Rounded mean: floor((2*sum + count) / (2*count)).
    assign numer = (NW'(sum_reg) << 1) + NW'(count_reg);
    assign denom = {count_reg, 1'b0};
    assign q0    = prod_reg[2*NW-1:NW];
    assign qd    = (NW+DW)'(q0) * (NW+DW)'(denom);
    assign rem   = (NW+DW)'(numer) - qd;
    assign quot  = q0 + NW'(rem >= (NW+DW)'(denom));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= ssmf_pkg::CFG_RESET;
            head_reg  <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            seen_reg  <= '0;
            fc_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            if (cmd.accept)
            begin
                head_reg <= wr_addr;
            end
            if (cfg_wr_en || cmd.clear)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                seen_reg  <= '0;
            end
            else if (cmd.update)
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                seen_reg  <= seen_next;
            end
            if (cmd.flush_init)
            begin
                fc_reg <= (seen_reg < CW'(h)) ? HW'(seen_reg) : h;
            end
            else if (cmd.flush_dec)
            begin
                fc_reg <= fc_reg - HW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_mm_reg    <= in_mm;
            in_valid_reg <= in_valid_flag;
            in_last_reg  <= in_last;
        end
        if (cmd.mul)
        begin
            prod_reg <= (2*NW)'(numer) * (2*NW)'(recip_tab[count_reg]);
        end
        if (cmd.fin)
        begin
            mean_reg <= RANGE_BITS'(quot);
        end
        if (cmd.load_out)
        begin
            out_mm_reg   <= cmd.out_mean ? mean_reg : rd_mm;
            out_flag_reg <= rd_flag;
            out_last_reg <= cmd.out_flush ? (fc_reg == HW'(1))
                                          : (in_last_reg && (h == '0));
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.has_centre = seen_reg > CW'(h);
    assign status.do_mean    = rd_flag && (seen_reg == w) && (count_reg != '0);
    assign status.last       = in_last_reg;
    assign status.fc_zero    = (fc_reg == '0);
    assign status.out_free   = out_free;

    assign out_valid      = out_valid_reg;
    assign out_mm         = out_mm_reg;
    assign out_valid_flag = out_flag_reg;
    assign out_last       = out_last_reg;

endmodule
